// ===== rtl/bhas_pkg.sv =====
// Shared types, constants and register indexes of the button hold and autorepeat scanner.
`timescale 1ns / 1ps
`default_nettype none
package bhas_pkg;

  // Number of button lanes and the width of a lane index.
  localparam int unsigned BUTTONS = 16;
  localparam int unsigned IdxW    = (BUTTONS > 1) ? $clog2(BUTTONS) : 1;

  // Buttons that have sample bits in an input item.
  localparam int unsigned SampledButtons = 16;

  // Field widths of one input item and one result item.
  localparam int unsigned TickW     = 32;
  localparam int unsigned LevelW    = 16;
  localparam int unsigned KindW     = 3;
  localparam int unsigned OutIdxW   = 4;
  localparam int unsigned InDataW   = TickW + 2 * LevelW;
  localparam int unsigned OutDataW  = ((KindW + OutIdxW + 7) / 8) * 8;

  // Configuration port widths.
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 8;
  localparam int unsigned TimeW     = 8;
  localparam int unsigned CountW    = 4;

  // Register indexes.
  localparam logic [CfgIdxW-1:0] RegHoldTime    = 3'd0;
  localparam logic [CfgIdxW-1:0] RegFirstRepeat = 3'd1;
  localparam logic [CfgIdxW-1:0] RegSlowRepeat  = 3'd2;
  localparam logic [CfgIdxW-1:0] RegFastRepeat  = 3'd3;
  localparam logic [CfgIdxW-1:0] RegSlowCount   = 3'd4;

  // Register reset values.
  localparam logic [TimeW-1:0]  HoldTimeRst    = 8'd25;
  localparam logic [TimeW-1:0]  FirstRepeatRst = 8'd20;
  localparam logic [TimeW-1:0]  SlowRepeatRst  = 8'd10;
  localparam logic [TimeW-1:0]  FastRepeatRst  = 8'd5;
  localparam logic [CountW-1:0] SlowCountRst   = 4'd3;

  // Phase of one button.
  typedef enum logic [1:0] {
    PhReleased = 2'd0,
    PhPushed   = 2'd1,
    PhHeld     = 2'd2,
    PhRepeat   = 2'd3
  } phase_e;

  // Event reported for a scan.
  typedef enum logic [KindW-1:0] {
    EvNone    = 3'd0,
    EvPush    = 3'd1,
    EvRelease = 3'd2,
    EvHold    = 3'd3,
    EvRepeat  = 3'd4
  } event_e;

  // Timing configuration shared by every lane.
  typedef struct packed {
    logic [TimeW-1:0]  hold_time;
    logic [TimeW-1:0]  first_repeat_time;
    logic [TimeW-1:0]  slow_repeat_time;
    logic [TimeW-1:0]  fast_repeat_time;
    logic [CountW-1:0] slow_repeat_count;
  } cfg_t;

  // Outcome of the merge stage.
  typedef struct packed {
    logic            hit;
    event_e          kind;
    logic [IdxW-1:0] idx;
  } merge_t;

endpackage
`default_nettype wire

// ===== rtl/bhas_lane.sv =====
// One button lane: phase machine, mark time and repeat counter of a single button.
`timescale 1ns / 1ps
`default_nettype none
module bhas_lane (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire bhas_pkg::cfg_t                     cfg_i,
  input  wire logic                               pressed_i,
  input  wire logic [bhas_pkg::TickW-1:0]         now_i,
  input  wire logic                               commit_i,
  output bhas_pkg::event_e                        ev_o
);

  bhas_pkg::phase_e                   phase_q, phase_d;
  logic [bhas_pkg::TickW-1:0]         mark_q, mark_d;
  logic [bhas_pkg::CountW-1:0]        count_q, count_d;
  logic [bhas_pkg::TimeW-1:0]         interval;
  logic [bhas_pkg::TickW-1:0]         limit;
  logic                               slow_phase;
  logic                               elapsed;

  // Delay that applies to the current phase, and the wrapped deadline.
  assign slow_phase = (count_q < cfg_i.slow_repeat_count);

  always_comb begin
    unique case (phase_q)
      bhas_pkg::PhPushed: interval = cfg_i.hold_time;
      bhas_pkg::PhHeld:   interval = cfg_i.first_repeat_time;
      default:            interval = slow_phase ? cfg_i.slow_repeat_time
                                                : cfg_i.fast_repeat_time;
    endcase
  end

  assign limit   = mark_q + bhas_pkg::TickW'(interval);
  assign elapsed = (now_i > limit);

  // Event this button would report in the current scan.
  always_comb begin
    if (phase_q == bhas_pkg::PhReleased) begin
      ev_o = pressed_i ? bhas_pkg::EvPush : bhas_pkg::EvNone;
    end else if (!pressed_i) begin
      ev_o = bhas_pkg::EvRelease;
    end else if (elapsed) begin
      ev_o = (phase_q == bhas_pkg::PhPushed) ? bhas_pkg::EvHold : bhas_pkg::EvRepeat;
    end else begin
      ev_o = bhas_pkg::EvNone;
    end
  end

  // Next state, taken only when this lane wins the scan.
  always_comb begin
    phase_d = phase_q;
    mark_d  = mark_q;
    count_d = count_q;
    if (commit_i) begin
      if (phase_q == bhas_pkg::PhReleased) begin
        phase_d = bhas_pkg::PhPushed;
        mark_d  = now_i;
      end else if (!pressed_i) begin
        phase_d = bhas_pkg::PhReleased;
        count_d = '0;
      end else begin
        mark_d = now_i;
        unique case (phase_q)
          bhas_pkg::PhPushed: phase_d = bhas_pkg::PhHeld;
          bhas_pkg::PhHeld:   phase_d = bhas_pkg::PhRepeat;
          default: begin
            if (slow_phase) begin
              count_d = count_q + 1'b1;
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= bhas_pkg::PhReleased;
      mark_q  <= '0;
      count_q <= '0;
    end else begin
      phase_q <= phase_d;
      mark_q  <= mark_d;
      count_q <= count_d;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/bhas_merge.sv =====
// Merge stage: picks the lowest-indexed lane that reports an event.
`timescale 1ns / 1ps
`default_nettype none
module bhas_merge (
  input  wire bhas_pkg::event_e             lane_ev_i [bhas_pkg::BUTTONS],
  output logic [bhas_pkg::BUTTONS-1:0]      win_o,
  output bhas_pkg::merge_t                  res_o
);

  // Scan from the top so the lowest index with an event takes priority.
  always_comb begin
    win_o      = '0;
    res_o.hit  = 1'b0;
    res_o.kind = bhas_pkg::EvNone;
    res_o.idx  = '0;
    for (int b = bhas_pkg::BUTTONS - 1; b >= 0; b--) begin
      if (lane_ev_i[b] != bhas_pkg::EvNone) begin
        win_o      = '0;
        win_o[b]   = 1'b1;
        res_o.hit  = 1'b1;
        res_o.kind = lane_ev_i[b];
        res_o.idx  = bhas_pkg::IdxW'(b);
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/button_hold_autorepeat_scanner.sv =====
// Top level of the button scanner: configuration, lanes, merge and result register.
//
//  Channel   Direction  Handshake                    Content
//  s_axis    in         s_axis_tvalid/tready         one scan item
//  m_axis    out        m_axis_tvalid/tready         one event item per scan
//  cfg       in         cfg_valid_i/cfg_ready_o      register index and value
//
//  For each scan item all lanes evaluate their button at once and the merge stage
//  selects the first event in the same cycle, with one 32-bit add and compare per
//  lane followed by the priority select.
//  The result sits in an output register; a new item is taken whenever that
//  register is empty or is being emptied in the same cycle.
//  Reset puts every button in the released phase with zero mark time and count,
//  and loads the default timing registers. The config port is always ready.
`timescale 1ns / 1ps
`default_nettype none
module button_hold_autorepeat_scanner (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // tdata: tick_now [31:0], first_levels [47:32], confirm_levels [63:48]
  input  wire logic [bhas_pkg::InDataW-1:0]      s_axis_tdata_i,
  input  wire logic                              s_axis_tvalid_i,
  output logic                                   s_axis_tready_o,
  // tdata: event_kind [2:0], button_index [6:3], zero [7]
  output logic [bhas_pkg::OutDataW-1:0]          m_axis_tdata_o,
  output logic                                   m_axis_tvalid_o,
  input  wire logic                              m_axis_tready_i,
  input  wire logic                              cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  wire logic [bhas_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  wire logic [bhas_pkg::CfgDataW-1:0]     cfg_data_i
);

  bhas_pkg::cfg_t                         cfg_q, cfg_d;
  logic [bhas_pkg::TickW-1:0]             now;
  logic [bhas_pkg::LevelW-1:0]            first_lv;
  logic [bhas_pkg::LevelW-1:0]            confirm_lv;
  logic                                   in_acc;
  logic                                   cfg_acc;
  bhas_pkg::event_e                       lane_ev [bhas_pkg::BUTTONS];
  logic [bhas_pkg::BUTTONS-1:0]           win;
  bhas_pkg::merge_t                       res;
  logic                                   out_valid_q, out_valid_d;
  bhas_pkg::event_e                       out_kind_q;
  logic [bhas_pkg::OutIdxW-1:0]           out_idx_q;

  // Input unpacking and handshakes.
  assign now        = s_axis_tdata_i[bhas_pkg::TickW-1:0];
  assign first_lv   = s_axis_tdata_i[bhas_pkg::TickW +: bhas_pkg::LevelW];
  assign confirm_lv = s_axis_tdata_i[bhas_pkg::TickW + bhas_pkg::LevelW +: bhas_pkg::LevelW];

  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  assign cfg_ready_o     = 1'b1;
  assign cfg_acc         = cfg_valid_i && cfg_ready_o;

  // Configuration registers; unknown indexes are ignored.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_acc) begin
      unique case (cfg_index_i)
        bhas_pkg::RegHoldTime:    cfg_d.hold_time         = cfg_data_i;
        bhas_pkg::RegFirstRepeat: cfg_d.first_repeat_time = cfg_data_i;
        bhas_pkg::RegSlowRepeat:  cfg_d.slow_repeat_time  = cfg_data_i;
        bhas_pkg::RegFastRepeat:  cfg_d.fast_repeat_time  = cfg_data_i;
        bhas_pkg::RegSlowCount:   cfg_d.slow_repeat_count = cfg_data_i[bhas_pkg::CountW-1:0];
        default:                  cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.hold_time         <= bhas_pkg::HoldTimeRst;
      cfg_q.first_repeat_time <= bhas_pkg::FirstRepeatRst;
      cfg_q.slow_repeat_time  <= bhas_pkg::SlowRepeatRst;
      cfg_q.fast_repeat_time  <= bhas_pkg::FastRepeatRst;
      cfg_q.slow_repeat_count <= bhas_pkg::SlowCountRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Button lanes; a lane without sample bits always reads as released.
  for (genvar b = 0; b < bhas_pkg::BUTTONS; b++) begin : g_lane
    logic pressed;
    if (b < bhas_pkg::SampledButtons) begin : g_sampled
      assign pressed = !first_lv[b] && !confirm_lv[b];
    end else begin : g_unsampled
      assign pressed = 1'b0;
    end

    bhas_lane u_lane (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .cfg_i     (cfg_q),
      .pressed_i (pressed),
      .now_i     (now),
      .commit_i  (in_acc && win[b]),
      .ev_o      (lane_ev[b])
    );
  end

  bhas_merge u_merge (
    .lane_ev_i (lane_ev),
    .win_o     (win),
    .res_o     (res)
  );

  // Result register.
  always_comb begin
    out_valid_d = out_valid_q;
    if (in_acc) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      out_kind_q <= res.kind;
      out_idx_q  <= bhas_pkg::OutIdxW'(res.idx);
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = bhas_pkg::OutDataW'({out_idx_q, out_kind_q});

  // An accepted scan always leaves a result behind.
  a_accept_fills : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> out_valid_q)
    else $error("accepted scan left no result");

  // At most one lane wins a scan, and only when some event exists.
  a_one_winner : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(win) && (res.hit == (win != '0)))
    else $error("merge selected more than one lane");

  // A scan without an event reports button zero.
  a_none_idx_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_kind_q == bhas_pkg::EvNone) |-> (out_idx_q == '0))
    else $error("empty result carries a button index");

  // A write to the slow count register lands in that register.
  a_cfg_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_acc && cfg_index_i == bhas_pkg::RegSlowCount) |=>
      (cfg_q.slow_repeat_count == $past(cfg_data_i[bhas_pkg::CountW-1:0])))
    else $error("slow repeat count write lost");

endmodule
`default_nettype wire

// ===== test/bhas_event_checker.sv =====
// Checker for the button scanner: predicts the event of every scan and compares results.
`timescale 1ns / 1ps
module bhas_event_checker
  import bhas_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [InDataW-1:0]  scan_tdata_i,
  input  logic                scan_tvalid_i,
  input  logic                scan_tready_i,
  input  logic [OutDataW-1:0] event_tdata_i,
  input  logic                event_tvalid_i,
  input  logic                event_tready_i,
  input  logic                cfg_valid_i,
  input  logic                cfg_ready_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output int                  mismatches_o,
  output int                  events_due_o
);

  // One expected event item.
  typedef struct packed {
    event_e              kind;
    logic [OutIdxW-1:0]  button;
  } scan_event_t;

  // Shadow timing registers and per-button state.
  cfg_t             timing_q;
  phase_e           lane_phase [BUTTONS];
  logic [TickW-1:0] lane_mark  [BUTTONS];
  logic [CountW-1:0] lane_count [BUTTONS];

  // Events predicted but not yet seen on the output.
  scan_event_t events_due [$];
  scan_event_t oldest;
  event_e      seen_kind;
  logic [OutIdxW-1:0] seen_button;

  initial mismatches_o = 0;
  initial events_due_o = 0;

  // Steps the buttons in index order and returns the first event of the scan.
  function automatic scan_event_t predict_scan(input logic [TickW-1:0] now,
                                               input logic [LevelW-1:0] first,
                                               input logic [LevelW-1:0] confirm);
    scan_event_t       ev;
    logic              pressed;
    logic [TimeW-1:0]  wait_ticks;
    logic [TickW-1:0]  due_tick;
    ev.kind   = EvNone;
    ev.button = '0;
    for (int b = 0; b < BUTTONS && ev.kind == EvNone; b++) begin
      // A button is down only when both samples read low.
      pressed = (b < SampledButtons) ? (!first[b] && !confirm[b]) : 1'b0;
      if (lane_phase[b] == PhReleased) begin
        if (pressed) begin
          lane_phase[b] = PhPushed;
          lane_mark[b]  = now;
          ev.kind       = EvPush;
        end
      end else if (!pressed) begin
        lane_phase[b] = PhReleased;
        lane_count[b] = '0;
        ev.kind       = EvRelease;
      end else begin
        case (lane_phase[b])
          PhPushed: wait_ticks = timing_q.hold_time;
          PhHeld:   wait_ticks = timing_q.first_repeat_time;
          default:  wait_ticks = (lane_count[b] < timing_q.slow_repeat_count) ?
                                 timing_q.slow_repeat_time : timing_q.fast_repeat_time;
        endcase
        // The deadline wraps at 32 bits; the compare is strict and unsigned.
        due_tick = lane_mark[b] + TickW'(wait_ticks);
        if (now > due_tick) begin
          lane_mark[b] = now;
          case (lane_phase[b])
            PhPushed: begin
              lane_phase[b] = PhHeld;
              ev.kind       = EvHold;
            end
            PhHeld: begin
              lane_phase[b] = PhRepeat;
              ev.kind       = EvRepeat;
            end
            default: begin
              if (lane_count[b] < timing_q.slow_repeat_count) begin
                lane_count[b] = lane_count[b] + 1'b1;
              end
              ev.kind = EvRepeat;
            end
          endcase
        end
      end
      if (ev.kind != EvNone) begin
        ev.button = OutIdxW'(b);
      end
    end
    return ev;
  endfunction

  // Track configuration, compare results against the oldest prediction, then predict.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timing_q.hold_time         = HoldTimeRst;
      timing_q.first_repeat_time = FirstRepeatRst;
      timing_q.slow_repeat_time  = SlowRepeatRst;
      timing_q.fast_repeat_time  = FastRepeatRst;
      timing_q.slow_repeat_count = SlowCountRst;
      for (int b = 0; b < BUTTONS; b++) begin
        lane_phase[b] = PhReleased;
        lane_mark[b]  = '0;
        lane_count[b] = '0;
      end
      events_due.delete();
      events_due_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          RegHoldTime:    timing_q.hold_time         = cfg_data_i;
          RegFirstRepeat: timing_q.first_repeat_time = cfg_data_i;
          RegSlowRepeat:  timing_q.slow_repeat_time  = cfg_data_i;
          RegFastRepeat:  timing_q.fast_repeat_time  = cfg_data_i;
          RegSlowCount:   timing_q.slow_repeat_count = cfg_data_i[CountW-1:0];
          default: ;
        endcase
      end

      if (event_tvalid_i && event_tready_i) begin
        seen_kind   = event_e'(event_tdata_i[KindW-1:0]);
        seen_button = event_tdata_i[KindW +: OutIdxW];
        if (events_due.size() == 0) begin
          $display("%0t: unexpected event item: kind %0d button %0d", $time,
                   seen_kind, seen_button);
          mismatches_o = mismatches_o + 1;
        end else begin
          oldest = events_due.pop_front();
          if (seen_kind != oldest.kind) begin
            $display("%0t: event_kind mismatch: expected %0d, actual %0d", $time,
                     oldest.kind, seen_kind);
            mismatches_o = mismatches_o + 1;
          end
          if (seen_button != oldest.button) begin
            $display("%0t: button_index mismatch: expected %0d, actual %0d", $time,
                     oldest.button, seen_button);
            mismatches_o = mismatches_o + 1;
          end
        end
      end

      if (scan_tvalid_i && scan_tready_i) begin
        events_due.push_back(predict_scan(scan_tdata_i[TickW-1:0],
                                          scan_tdata_i[TickW +: LevelW],
                                          scan_tdata_i[TickW+LevelW +: LevelW]));
      end
      events_due_o <= events_due.size();
    end
  end

endmodule

// ===== test/testbench.sv =====
// Top of the button scanner test: clock, reset, scan stimulus, timing setup and verdict.
`timescale 1ns / 1ps
module testbench;
  import bhas_pkg::*;

  localparam int CycleLimit   = 200000;
  localparam int ScansPerPass = 175;
  localparam int Passes       = 8;

  logic                clk_i           = 1'b0;
  logic                rst_ni          = 1'b0;
  logic [InDataW-1:0]  s_axis_tdata_i  = '0;
  logic                s_axis_tvalid_i = 1'b0;
  logic                s_axis_tready_o;
  logic [OutDataW-1:0] m_axis_tdata_o;
  logic                m_axis_tvalid_o;
  logic                m_axis_tready_i = 1'b0;
  logic                cfg_valid_i     = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i     = '0;
  logic [CfgDataW-1:0] cfg_data_i      = '0;

  int mismatches;
  int events_due;

  // Traffic shaping, set by the stimulus and read by the scan sender and the receiver.
  int idle_pct         = 0;
  int stall_pct        = 0;
  int squeeze_requests = 0;
  int squeeze_served   = 0;
  int squeeze_left     = 0;
  int cycles           = 0;

  // Button and time state of the scan generator.
  logic [LevelW-1:0] held_mask = '0;
  logic [TickW-1:0]  tick_now  = '0;

  button_hold_autorepeat_scanner i_dut (
    .clk_i,
    .rst_ni,
    .s_axis_tdata_i,
    .s_axis_tvalid_i,
    .s_axis_tready_o,
    .m_axis_tdata_o,
    .m_axis_tvalid_o,
    .m_axis_tready_i,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_index_i,
    .cfg_data_i
  );

  bhas_event_checker i_checker (
    .clk_i,
    .rst_ni,
    .scan_tdata_i   (s_axis_tdata_i),
    .scan_tvalid_i  (s_axis_tvalid_i),
    .scan_tready_i  (s_axis_tready_o),
    .event_tdata_i  (m_axis_tdata_o),
    .event_tvalid_i (m_axis_tvalid_o),
    .event_tready_i (m_axis_tready_i),
    .cfg_valid_i,
    .cfg_ready_i    (cfg_ready_o),
    .cfg_index_i,
    .cfg_data_i,
    .mismatches_o   (mismatches),
    .events_due_o   (events_due)
  );

  // Clock generation.
  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // Result receiver: random stalls, plus a long hold-off when the stimulus asks for one.
  always @(posedge clk_i) begin
    if (squeeze_served != squeeze_requests) begin
      squeeze_served = squeeze_requests;
      squeeze_left   = 250;
    end
    if (squeeze_left > 0) begin
      squeeze_left    = squeeze_left - 1;
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycles = cycles + 1;
    if (cycles > CycleLimit) begin
      $display("%0t: run did not finish within %0d cycles", $time, CycleLimit);
      $display("== FAIL ==");
      $finish;
    end
  end

  // Offers one scan item, after random idle cycles, and waits until it is taken.
  task automatic send_scan(input logic [TickW-1:0] tick, input logic [LevelW-1:0] first,
                           input logic [LevelW-1:0] confirm);
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {confirm, first, tick};
    do @(posedge clk_i); while (!s_axis_tready_o);
  endtask

  // Builds a scan from the held buttons with time steps, contact bounce and glitches.
  task automatic random_scan();
    int                roll;
    logic [LevelW-1:0] bounce;
    logic [LevelW-1:0] split;
    logic [LevelW-1:0] glitch;
    roll = $urandom_range(99);
    if (roll < 6) begin
      held_mask[$urandom_range(LevelW-1)] ^= 1'b1;
    end else if (roll < 8) begin
      held_mask = LevelW'($urandom & $urandom);
    end else if (roll < 9) begin
      held_mask = '0;
    end else if (roll < 10) begin
      held_mask = LevelW'($urandom);
    end
    roll = $urandom_range(99);
    if (roll < 70) begin
      tick_now = tick_now + $urandom_range(8);
    end else if (roll < 95) begin
      tick_now = tick_now + $urandom_range(64);
    end else if (roll < 99) begin
      tick_now = tick_now + $urandom_range(600);
    end else begin
      tick_now = $urandom;
    end
    // A bouncing button shows low in only one of its two samples.
    bounce = ($urandom_range(99) < 20) ? (LevelW'($urandom & $urandom) & ~held_mask) : '0;
    split  = LevelW'($urandom);
    glitch = ($urandom_range(99) < 3) ? (LevelW'(1) << $urandom_range(LevelW-1)) & held_mask
                                      : '0;
    send_scan(tick_now, ~(held_mask | (bounce & split)) | glitch,
              ~(held_mask | (bounce & ~split)));
  endtask

  // Holds the scan input idle until every predicted event has been delivered.
  task automatic drain_events();
    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (events_due != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Presents one register write and waits for it to be taken.
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  // Loads one timing setting: all zero, all maximum, short with a masked count, or random.
  task automatic load_timing(input int sel);
    logic [CfgDataW-1:0] val [5];
    case (sel)
      0: val = '{8'd0, 8'd0, 8'd0, 8'd0, 8'd0};
      1: val = '{8'd255, 8'd255, 8'd255, 8'd255, 8'd15};
      2: val = '{8'd3, 8'd2, 8'd1, 8'd0, 8'hF2};
      default: begin
        for (int r = 0; r < 5; r++) begin
          val[r] = CfgDataW'($urandom_range(40));
        end
        val[4] = CfgDataW'($urandom);
      end
    endcase
    write_reg(RegHoldTime, val[0]);
    write_reg(RegFirstRepeat, val[1]);
    write_reg(RegSlowRepeat, val[2]);
    write_reg(RegFastRepeat, val[3]);
    write_reg(RegSlowCount, val[4]);
    // Indexes past the last register must be ignored.
    write_reg(RegSlowCount + CfgIdxW'(1 + $urandom_range(2)), CfgDataW'($urandom));
    cfg_valid_i <= 1'b0;
  endtask

  // Stimulus and verdict.
  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed scans under the reset timing.
    send_scan(32'd0, 16'hFFFF, 16'hFFFF);
    send_scan(32'd1, 16'hFFF7, 16'hFFFF);
    send_scan(32'd2, 16'h7FFF, 16'h7FFF);
    send_scan(32'd3, 16'h7FFB, 16'h7FFB);
    // Buttons 2 and 15 held through hold, first repeat and slow repeats.
    for (int k = 0; k < 10; k++) begin
      send_scan(TickW'(30 + k * 9), 16'h7FFB, 16'h7FFB);
    end
    send_scan(32'd200, 16'hFFFF, 16'hFFFF);
    send_scan(32'd201, 16'hFFFF, 16'hFFFF);
    // Hold deadline that wraps past the top of the tick range.
    send_scan(32'hFFFF_FFF0, 16'hFF7F, 16'hFF7F);
    send_scan(32'hFFFF_FFFA, 16'hFF7F, 16'hFF7F);
    send_scan(32'h0000_0004, 16'h0000, 16'h0000);
    send_scan(32'h0000_0005, 16'h0000, 16'h0000);
    send_scan(32'h0000_0006, 16'hFFFF, 16'hFFFF);
    tick_now = 32'h0000_0006;
    drain_events();

    // Random passes, each with its own timing setting and traffic pattern.
    for (int p = 0; p < Passes; p++) begin
      load_timing((p + p / 4) % 4);
      case (p % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 72; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 72; end
        default: begin idle_pct = 16; stall_pct = 16; end
      endcase
      for (int n = 0; n < ScansPerPass; n++) begin
        if (p == 0 && n == 40) begin
          squeeze_requests = squeeze_requests + 1;
        end
        random_scan();
      end
      drain_events();
    end

    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== button_hold_autorepeat_scanner.f =====
rtl/bhas_pkg.sv
rtl/bhas_lane.sv
rtl/bhas_merge.sv
rtl/button_hold_autorepeat_scanner.sv
test/bhas_event_checker.sv
test/testbench.sv
